// ===== rtl/pbo_pkg.sv =====
// Shared constants and types for the polygon versus box overlap block.
// Used by pbo_div, polygon_box_overlap_test_unit and its bench; depends on nothing.
package pbo_pkg;

  localparam int MAX_VERTICES = 8;
  localparam int FRAC_BITS    = 16;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = 4;
  localparam int COORD_W      = 32;
  localparam int HALF_W       = 31;
  // working width for differences, sums and clip offsets
  localparam int WIDE_W       = 40;
  // dividend magnitude: numerator scaled by one
  localparam int DVD_W        = WIDE_W + FRAC_BITS;
  localparam int DCNT_W       = $clog2(DVD_W);
  localparam int Q_W          = DVD_W + 2;
  localparam int MUL_A_W      = 34;
  localparam int MUL_B_W      = FRAC_BITS + 2;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_TEST   = 2'd2;

  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [Q_W-1:0]    quo_t;
  typedef logic [2:0][COORD_W-1:0]  vtx_t;

endpackage

// ===== rtl/pbo_div.sv =====
// Iterative signed fixed-point divider: (num * 2^FRAC_BITS) / den, truncated toward zero.
// One quotient bit per cycle; depends on pbo_pkg.
module pbo_div import pbo_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  wide_t num,
  input  wide_t den,
  output logic  busy,
  output logic  done,
  output quo_t  quo
);

  logic              busy_r, done_r, neg_r;
  logic [DCNT_W-1:0] cnt_r;
  logic [DVD_W-1:0]  dvd_r, quo_r;
  logic [WIDE_W-1:0] dsr_r, rem_r;
  logic [WIDE_W-1:0] num_mag, den_mag;
  logic [WIDE_W:0]   trial;
  logic              ge;

  // magnitudes of the operands
  assign num_mag = num[WIDE_W-1] ? WIDE_W'(-num) : WIDE_W'(num);
  assign den_mag = den[WIDE_W-1] ? WIDE_W'(-den) : WIDE_W'(den);

  // restoring step
  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign ge    = trial >= {1'b0, dsr_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DCNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      dvd_r <= {num_mag, FRAC_BITS'(0)};
      dsr_r <= den_mag;
      rem_r <= '0;
      quo_r <= '0;
      neg_r <= num[WIDE_W-1] ^ den[WIDE_W-1];
    end else if (busy_r) begin
      rem_r <= ge ? WIDE_W'(trial - {1'b0, dsr_r}) : trial[WIDE_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = neg_r ? -$signed({2'b00, quo_r}) : $signed({2'b00, quo_r});

endmodule

// ===== rtl/polygon_box_overlap_test_unit.sv =====
// Polygon versus axis-aligned cube overlap test, signed Q16.16; top level.
// Depends on pbo_pkg and pbo_div.
//
// Holds one polygon of up to 8 vertices in a small synchronous memory. Start and
// append beats produce no result; an append past capacity is dropped and flagged.
// A test beat yields one result beat. Its latency is set by the single shared
// divider (up to six quotients per face plane) and the single read port of the
// vertex memory: an outcode pass over all vertices, then per vertex three reads
// plus work on each of six face planes; an early hit or outcode reject ends the
// test early. No new beat is taken while a test runs; a finished result waits in
// an output register.
module polygon_box_overlap_test_unit import pbo_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_opcode,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic signed [COORD_W-1:0] in_coord_z,
  input  logic [HALF_W-1:0]         in_half_size,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_hit,
  output logic                      out_overflowed,
  output logic [CNT_W-1:0]          out_vertices_held
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_OC_RD  = 5'd1;
  localparam logic [4:0] S_OC_AC  = 5'd2;
  localparam logic [4:0] S_RD_P   = 5'd3;
  localparam logic [4:0] S_RD_M   = 5'd4;
  localparam logic [4:0] S_RD_N   = 5'd5;
  localparam logic [4:0] S_LD_N   = 5'd6;
  localparam logic [4:0] S_VTX    = 5'd7;
  localparam logic [4:0] S_PLANE  = 5'd8;
  localparam logic [4:0] S_DIV_GO = 5'd9;
  localparam logic [4:0] S_DIV_WT = 5'd10;
  localparam logic [4:0] S_CHK    = 5'd11;
  localparam logic [4:0] S_MUL    = 5'd12;
  localparam logic [4:0] S_DIFF   = 5'd13;
  localparam logic [4:0] S_CMP    = 5'd14;
  localparam logic [4:0] S_NEXT   = 5'd15;
  localparam logic [4:0] S_DONE   = 5'd16;

  localparam quo_t ONE = quo_t'(1) <<< FRAC_BITS;

  function automatic wide_t sx(input logic [COORD_W-1:0] v);
    sx = {{(WIDE_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

  function automatic logic [COORD_W-1:0] pick(input vtx_t v, input logic [1:0] ax);
    unique case (ax)
      2'd0:    pick = v[0];
      2'd1:    pick = v[1];
      default: pick = v[2];
    endcase
  endfunction

  logic [4:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic              ovf_r;
  logic [VIDX_W-1:0] i_r;
  logic [5:0]        acc_r;
  logic [1:0]        j_r;
  logic              k_r;
  logic [2:0]        dcnt_r;
  logic [2:0]        mcnt_r;
  logic              hit_r;
  vtx_t              c_r, prv_r, mid_r, nxt_r;
  logic [HALF_W-1:0] s_r;
  quo_t              t1_r, t2_r;
  quo_t              ent_r [2];
  quo_t              lev_r [2];
  logic signed [PROD_W-1:0] prod_r;
  wide_t             sh_r [4];
  wide_t             d_r [2];
  wide_t             off_r [2];

  logic              out_valid_r, out_hit_r, out_ovf_r;
  logic [CNT_W-1:0]  out_cnt_r;

  // vertex memory
  vtx_t              vmem [MAX_VERTICES];
  vtx_t              rd_data_r;
  logic [VIDX_W-1:0] rd_addr, wr_addr;
  logic              wr_en;

  logic              in_acc, out_acc, emit;
  wide_t             s_w, lo_b [3], hi_b [3];
  wide_t             e1 [3], e2 [3];
  logic [5:0]        code;
  logic              mid_in;
  logic [CNT_W-1:0]  ia_sum, ib_sum;
  logic [VIDX_W-1:0] ia, ib;
  logic              last_i;
  logic [1:0]        ax0, ax1;
  wide_t             num_plane, e1j, e2j;
  wide_t             p0, p1, d0, d1, o0, o1, sg0, sg1;
  wide_t             div_num, div_den;
  logic              div_start, div_busy, div_done;
  quo_t              div_quo;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  quo_t              lo_q, hi_q;
  logic              t_bad;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid_r && !out_stall;
  assign emit      = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // box bounds and edge vectors per axis
  assign s_w = wide_t'({1'b0, s_r});
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lo_b[a] = sx(c_r[a]) - s_w;
      hi_b[a] = sx(c_r[a]) + s_w;
      e1[a]   = sx(prv_r[a]) - sx(mid_r[a]);
      e2[a]   = sx(nxt_r[a]) - sx(mid_r[a]);
    end
  end

  // outcode of the vertex just read, and containment of the middle vertex
  always_comb begin
    mid_in = 1'b1;
    for (int a = 0; a < 3; a++) begin
      code[2*a]   = $signed(sx(rd_data_r[a])) < lo_b[a];
      code[2*a+1] = $signed(sx(rd_data_r[a])) > hi_b[a];
      if (sx(mid_r[a]) < lo_b[a] || sx(mid_r[a]) > hi_b[a]) begin
        mid_in = 1'b0;
      end
    end
  end

  // cyclic neighbor indices
  assign ia_sum = {1'b0, i_r} + 1'b1;
  assign ia     = (ia_sum >= cnt_r) ? VIDX_W'(ia_sum - cnt_r) : ia_sum[VIDX_W-1:0];
  assign ib_sum = {1'b0, ia} + 1'b1;
  assign ib     = (ib_sum >= cnt_r) ? VIDX_W'(ib_sum - cnt_r) : ib_sum[VIDX_W-1:0];
  assign last_i = ({1'b0, i_r} == CNT_W'(cnt_r - 1'b1));

  // face plane on axis j, clipped against the two other axes
  assign ax0 = (j_r == 2'd0) ? 2'd1 : (j_r == 2'd1) ? 2'd2 : 2'd0;
  assign ax1 = (j_r == 2'd0) ? 2'd2 : (j_r == 2'd1) ? 2'd0 : 2'd1;
  always_comb begin
    e1j = '0;
    e2j = '0;
    for (int a = 0; a < 3; a++) begin
      if (j_r == 2'(a)) begin
        e1j = e1[a];
        e2j = e2[a];
      end
    end
  end
  assign num_plane = (k_r ? s_w : -s_w) + sx(pick(c_r, j_r)) - sx(pick(mid_r, j_r));

  // cut points and clip direction
  assign p0  = sx(pick(mid_r, ax0)) + sh_r[0];
  assign p1  = sx(pick(mid_r, ax1)) + sh_r[1];
  assign d0  = sh_r[2] - sh_r[0];
  assign d1  = sh_r[3] - sh_r[1];
  assign o0  = p0 - sx(pick(c_r, ax0));
  assign o1  = p1 - sx(pick(c_r, ax1));
  assign sg0 = (d_r[0] >= 0) ? s_w : -s_w;
  assign sg1 = (d_r[1] >= 0) ? s_w : -s_w;

  // divider operand select
  always_comb begin
    unique case (dcnt_r)
      3'd0:    begin div_num = num_plane;        div_den = e1j;     end
      3'd1:    begin div_num = num_plane;        div_den = e2j;     end
      3'd2:    begin div_num = -sg0 - off_r[0];  div_den = d_r[0];  end
      3'd3:    begin div_num = sg0 - off_r[0];   div_den = d_r[0];  end
      3'd4:    begin div_num = -sg1 - off_r[1];  div_den = d_r[1];  end
      default: begin div_num = sg1 - off_r[1];   div_den = d_r[1];  end
    endcase
  end
  assign div_start = (state_r == S_DIV_GO);

  pbo_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (div_quo)
  );

  // multiplier operand select
  always_comb begin
    unique case (mcnt_r[1:0])
      2'd0:    begin mul_a = MUL_A_W'(e1[ax0]); mul_b = MUL_B_W'(t1_r); end
      2'd1:    begin mul_a = MUL_A_W'(e1[ax1]); mul_b = MUL_B_W'(t1_r); end
      2'd2:    begin mul_a = MUL_A_W'(e2[ax0]); mul_b = MUL_B_W'(t2_r); end
      default: begin mul_a = MUL_A_W'(e2[ax1]); mul_b = MUL_B_W'(t2_r); end
    endcase
  end

  assign t_bad = (t1_r < 0) || (t1_r > ONE) || (t2_r < 0) || (t2_r > ONE);
  assign lo_q  = (ent_r[0] > ent_r[1]) ? ent_r[0] : ent_r[1];
  assign hi_q  = (lev_r[0] < lev_r[1]) ? lev_r[0] : lev_r[1];

  // memory ports
  always_comb begin
    unique case (state_r)
      S_RD_M:  rd_addr = ia;
      S_RD_N:  rd_addr = ib;
      default: rd_addr = i_r;
    endcase
  end
  assign wr_en   = in_acc && ((in_opcode == OP_START) ||
                  (in_opcode == OP_APPEND && cnt_r < CNT_W'(MAX_VERTICES)));
  assign wr_addr = (in_opcode == OP_START) ? '0 : cnt_r[VIDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vmem[wr_addr] <= {in_coord_z, in_coord_y, in_coord_x};
    end
    rd_data_r <= vmem[rd_addr];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_acc && in_opcode == OP_TEST) begin
                  state_nxt = (cnt_r == '0) ? S_DONE : S_OC_RD;
                end
      S_OC_RD:  state_nxt = S_OC_AC;
      S_OC_AC:  if (last_i) begin
                  state_nxt = ((acc_r & code) != '0) ? S_DONE : S_RD_P;
                end else begin
                  state_nxt = S_OC_RD;
                end
      S_RD_P:   state_nxt = S_RD_M;
      S_RD_M:   state_nxt = S_RD_N;
      S_RD_N:   state_nxt = S_LD_N;
      S_LD_N:   state_nxt = S_VTX;
      S_VTX:    state_nxt = mid_in ? S_DONE : S_PLANE;
      S_PLANE:  state_nxt = (e1j == '0 || e2j == '0) ? S_NEXT : S_DIV_GO;
      S_DIV_GO: state_nxt = S_DIV_WT;
      S_DIV_WT: if (div_done) begin
                  state_nxt = (dcnt_r == 3'd1) ? S_CHK :
                              (dcnt_r == 3'd5) ? S_CMP : S_DIV_GO;
                end
      S_CHK:    state_nxt = t_bad ? S_NEXT : S_MUL;
      S_MUL:    if (mcnt_r == 3'd4) state_nxt = S_DIFF;
      S_DIFF:   state_nxt = (d0 == '0 || d1 == '0) ? S_NEXT : S_DIV_GO;
      S_CMP:    state_nxt = (lo_q <= hi_q && lo_q >= 0 && lo_q <= ONE) ? S_DONE : S_NEXT;
      S_NEXT:   if (j_r == 2'd2 && k_r) begin
                  state_nxt = last_i ? S_DONE : S_RD_P;
                end else begin
                  state_nxt = S_PLANE;
                end
      S_DONE:   if (emit) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && in_opcode == OP_START) begin
        cnt_r <= CNT_W'(1);
        ovf_r <= 1'b0;
      end else if (in_acc && in_opcode == OP_APPEND) begin
        if (cnt_r < CNT_W'(MAX_VERTICES)) begin
          cnt_r <= cnt_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      S_IDLE: begin
        c_r   <= {in_coord_z, in_coord_y, in_coord_x};
        s_r   <= in_half_size;
        i_r   <= '0;
        acc_r <= '1;
        hit_r <= 1'b0;
      end
      S_OC_AC: begin
        acc_r <= acc_r & code;
        i_r   <= last_i ? '0 : i_r + 1'b1;
      end
      S_RD_M: prv_r <= rd_data_r;
      S_RD_N: mid_r <= rd_data_r;
      S_LD_N: begin
        nxt_r <= rd_data_r;
        j_r   <= '0;
        k_r   <= 1'b0;
      end
      S_VTX:   hit_r <= mid_in;
      S_PLANE: dcnt_r <= '0;
      S_DIV_WT: if (div_done) begin
        unique case (dcnt_r)
          3'd0:    t1_r     <= div_quo;
          3'd1:    t2_r     <= div_quo;
          3'd2:    ent_r[0] <= div_quo;
          3'd3:    lev_r[0] <= div_quo;
          3'd4:    ent_r[1] <= div_quo;
          default: lev_r[1] <= div_quo;
        endcase
        dcnt_r <= dcnt_r + 1'b1;
      end
      S_CHK: mcnt_r <= '0;
      S_MUL: begin
        mcnt_r <= mcnt_r + 1'b1;
        if (mcnt_r != '0) begin
          sh_r[mcnt_r[1:0] - 2'd1] <= WIDE_W'(prod_r >>> FRAC_BITS);
        end
      end
      S_DIFF: begin
        d_r[0]   <= d0;
        d_r[1]   <= d1;
        off_r[0] <= o0;
        off_r[1] <= o1;
        dcnt_r   <= 3'd2;
      end
      S_CMP: hit_r <= (lo_q <= hi_q && lo_q >= 0 && lo_q <= ONE);
      S_NEXT: begin
        k_r <= ~k_r;
        if (k_r) begin
          j_r <= (j_r == 2'd2) ? 2'd0 : j_r + 1'b1;
          if (j_r == 2'd2) i_r <= i_r + 1'b1;
        end
      end
      default: ;
    endcase
    if (emit) begin
      out_hit_r <= hit_r;
      out_ovf_r <= ovf_r;
      out_cnt_r <= cnt_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_overflowed    = out_ovf_r;
  assign out_vertices_held = out_cnt_r;

  // checks
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond capacity");

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_empty_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && cnt_r == '0) |=> !out_hit)
    else $error("empty polygon reported a hit");

endmodule

// ===== tb/polygon_box_overlap_test_unit_tb.sv =====
// Self-checking bench for polygon_box_overlap_test_unit: directed and random polygons and cube tests.
// Depends on pbo_pkg and the RTL top; predicts each test beat with a fixed-point overlap model.
module polygon_box_overlap_test_unit_tb;
  import pbo_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]         op;
    logic signed [31:0] x, y, z;
    logic [30:0]        h;
    bit                 drain;   // hold until every pending result has come back
  } beat_t;

  typedef struct {
    logic       hit;
    logic       ovf;
    logic [3:0] cnt;
  } answer_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                in_opcode = '0;
  logic signed [COORD_W-1:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic [HALF_W-1:0]         in_half_size = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic                      out_hit, out_overflowed;
  logic [CNT_W-1:0]          out_vertices_held;

  beat_t   pend_beats[$];
  answer_t answers_due[$];
  int      errors = 0;
  int      results_seen = 0;

  // shadow copy of the polygon
  longint     poly[MAX_VERTICES][3];
  int unsigned poly_cnt = 0;
  bit          poly_ovf = 1'b0;

  polygon_box_overlap_test_unit u_top (.*);

  // clock, 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------- predictor ----------------
  function automatic longint q_div(longint num, longint den);
    return (num * (64'sd1 <<< FRAC_BITS)) / den;
  endfunction

  function automatic bit pt_in_box(longint px, longint py, longint pz,
                                   longint cx, longint cy, longint cz, longint s);
    return !(px < cx - s || px > cx + s || py < cy - s || py > cy + s ||
             pz < cz - s || pz > cz + s);
  endfunction

  function automatic bit box_overlap(longint cx, longint cy, longint cz, longint s);
    longint one;
    longint c[3];
    longint e1[3], e2[3], p[3], d[3], entry[2], leave[2];
    longint num, t1, t2, off, sg, lo, hi;
    int unsigned acc, code, n, im, ip, inx;
    int ax, m;
    bit skip;
    one = 64'sd1 <<< FRAC_BITS;
    c[0] = cx; c[1] = cy; c[2] = cz;
    n = poly_cnt;
    acc = 8'hff;
    for (int i = 0; i < n; i++) begin
      code = 0;
      for (int a = 2; a >= 0; a--) begin
        code = (code << 2) | ((poly[i][a] < c[a] - s) ? 1 : 0) |
               ((poly[i][a] > c[a] + s) ? 2 : 0);
      end
      acc &= code;
    end
    if (acc != 0) return 1'b0;
    for (int i = 0; i < n; i++) begin
      ip = i; im = (i + 1) % n; inx = (i + 2) % n;
      for (int a = 0; a < 3; a++) begin
        e1[a] = poly[ip][a] - poly[im][a];
        e2[a] = poly[inx][a] - poly[im][a];
      end
      if (pt_in_box(poly[im][0], poly[im][1], poly[im][2], cx, cy, cz, s)) return 1'b1;
      for (int j = 0; j < 3; j++) begin
        for (int k = -1; k <= 1; k += 2) begin
          skip = 1'b0;
          if (e1[j] == 0 || e2[j] == 0) continue;
          num = (k < 0 ? -s : s) + c[j] - poly[im][j];
          t1 = q_div(num, e1[j]);
          t2 = q_div(num, e2[j]);
          if (t1 < 0 || t1 > one || t2 < 0 || t2 > one) continue;
          for (int a = 0; a < 3; a++) begin
            p[a] = poly[im][a] + ((e1[a] * t1) >>> FRAC_BITS);
            d[a] = poly[im][a] + ((e2[a] * t2) >>> FRAC_BITS) - p[a];
          end
          for (m = 0; m < 2; m++) begin
            ax = (j + 1 + m) % 3;
            off = p[ax] - c[ax];
            sg = d[ax] >= 0 ? s : -s;
            if (d[ax] == 0) begin
              skip = 1'b1;
              break;
            end
            entry[m] = q_div(-sg - off, d[ax]);
            leave[m] = q_div(sg - off, d[ax]);
          end
          if (skip) continue;
          lo = entry[0] > entry[1] ? entry[0] : entry[1];
          hi = leave[0] < leave[1] ? leave[0] : leave[1];
          if (lo <= hi && lo >= 0 && lo <= one) return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // apply one accepted beat to the shadow polygon, queue the answer of a test
  task automatic predict_beat(logic [1:0] op, logic signed [31:0] x, y, z, logic [30:0] h);
    answer_t ans;
    case (op)
      OP_START: begin
        poly[0][0] = x; poly[0][1] = y; poly[0][2] = z;
        poly_cnt = 1;
        poly_ovf = 1'b0;
      end
      OP_APPEND: begin
        if (poly_cnt < MAX_VERTICES) begin
          poly[poly_cnt][0] = x; poly[poly_cnt][1] = y; poly[poly_cnt][2] = z;
          poly_cnt++;
        end else begin
          poly_ovf = 1'b1;
        end
      end
      OP_TEST: begin
        ans.hit = box_overlap(x, y, z, longint'(h));
        ans.ovf = poly_ovf;
        ans.cnt = poly_cnt[3:0];
        answers_due.push_back(ans);
      end
      default: ;
    endcase
  endtask

  // ---------------- stimulus build ----------------
  task automatic add_beat(logic [1:0] op, longint x, y, z, longint h, bit drain = 1'b0);
    beat_t b;
    b.op = op; b.x = x[31:0]; b.y = y[31:0]; b.z = z[31:0]; b.h = h[30:0]; b.drain = drain;
    pend_beats.push_back(b);
  endtask

  function automatic longint near(longint base, longint spread);
    longint v;
    v = base + longint'($urandom_range(0, 2 * spread)) - spread;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v;
  endfunction

  function automatic longint any_coord();
    return longint'($signed($urandom()));
  endfunction

  initial begin
    longint bx, by, bz, spread;
    int nv, nt, poly_idx;
    // directed part
    add_beat(OP_TEST, 0, 0, 0, 32'h10000);                       // empty polygon
    add_beat(OP_APPEND, 32'h10000, 0, 0, 0);                     // append with no start
    add_beat(OP_APPEND, 0, 32'h10000, 0, 0);
    add_beat(OP_TEST, 0, 0, 0, 32'h8000);
    add_beat(OP_START, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 0);
    add_beat(OP_APPEND, -64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 0);
    add_beat(OP_APPEND, -64'sd2147483648, 64'sd2147483647, 0, 0);
    add_beat(OP_TEST, 0, 0, 0, 31'h7fffffff);                    // huge cube
    add_beat(OP_TEST, -64'sd2147483648, 64'sd2147483647, 0, 0);  // zero-size cube at extremes
    add_beat(OP_TEST, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647, 31'h7fffffff);
    add_beat(2'd3, 64'sd2147483647, 64'sd2147483647, 64'sd2147483647, 31'h7fffffff); // ignored
    // triangle spanning a small cube, no vertex inside: edge clipping
    add_beat(OP_START, -32'sh50000, -32'sh10000, 0, 0);
    add_beat(OP_APPEND, 32'sh50000, -32'sh10000, 0, 0);
    add_beat(OP_APPEND, 0, 32'sh60000, 0, 0);
    add_beat(OP_TEST, 0, 0, 0, 32'h8000);
    add_beat(OP_TEST, 0, 0, 32'sh40000, 32'h8000);               // outcode reject
    // flat-in-x polygon: zero divisors on that axis
    add_beat(OP_START, 32'sh10000, 0, 0, 0);
    add_beat(OP_APPEND, 32'sh10000, 32'sh30000, 0, 0);
    add_beat(OP_APPEND, 32'sh10000, 0, 32'sh30000, 0);
    add_beat(OP_TEST, 32'sh10000, 32'sh10000, 32'sh10000, 32'h4000);
    // overflow: nine appends past start
    add_beat(OP_START, 0, 0, 0, 0);
    for (int i = 0; i < 9; i++) add_beat(OP_APPEND, i * 32'sh8000, 32'sh20000, -i * 32'sh4000, 0);
    add_beat(OP_TEST, 32'sh40000, 32'sh10000, 0, 32'h10000);
    add_beat(OP_START, 32'sh10000, 32'sh10000, 32'sh10000, 0);   // start clears the flag
    add_beat(OP_TEST, 32'sh10000, 32'sh10000, 32'sh10000, 0);

    // random part: polygons with tests, some over capacity or without start, some noise
    poly_idx = 0;
    while (pend_beats.size() < 1450) begin
      poly_idx++;
      if ($urandom_range(0, 9) == 0) begin
        // noise beat: any opcode, full-range fields
        add_beat(2'($urandom_range(0, 3)), any_coord(), any_coord(), any_coord(),
                 longint'($urandom() & 32'h7fffffff));
        continue;
      end
      case ($urandom_range(0, 3))
        0: spread = 64'sd1 <<< 14;
        1: spread = 64'sd1 <<< 18;
        2: spread = 64'sd1 <<< 22;
        default: spread = 64'sd1 <<< 30;
      endcase
      bx = near(0, 64'sd1 <<< 30); by = near(0, 64'sd1 <<< 30); bz = near(0, 64'sd1 <<< 30);
      nv = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 6);
      if ($urandom_range(0, 15) != 0)
        add_beat(OP_START, near(bx, spread), near(by, spread), near(bz, spread), 0);
      for (int i = 1; i < nv; i++)
        add_beat(OP_APPEND, near(bx, spread), near(by, spread), near(bz, spread), 0);
      nt = $urandom_range(1, 4);
      for (int i = 0; i < nt; i++)
        add_beat(OP_TEST, near(bx, spread), near(by, spread), near(bz, spread),
                 longint'($urandom_range(0, 32'(spread))), (poly_idx % 60 == 30) && i == 0);
    end
  end

  // ---------------- reset ----------------
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  // ---------------- input driver ----------------
  bit took = 1'b0;
  int gap_left = 0, burst_left = 0;

  always @(negedge clk) begin
    beat_t b;
    if (rst_n && (!in_valid || took)) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pend_beats.size() > 0 &&
                   !(pend_beats[0].drain && answers_due.size() > 0)) begin
        b = pend_beats.pop_front();
        in_opcode <= b.op;
        in_coord_x <= b.x;
        in_coord_y <= b.y;
        in_coord_z <= b.z;
        in_half_size <= b.h;
        in_valid <= 1'b1;
        burst_left--;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- result stall pattern ----------------
  int cyc = 0;
  int hold_left = 0;
  bit held_once = 1'b0;

  always @(negedge clk) begin
    cyc++;
    if (!held_once && results_seen >= 80) begin
      held_once = 1'b1;
      hold_left = 3000;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case ((cyc / 300) % 3)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // ---------------- monitor: accept, predict and compare ----------------
  always @(posedge clk) begin
    answer_t want;
    took <= in_valid && !in_stall && rst_n;
    if (rst_n && in_valid && !in_stall)
      predict_beat(in_opcode, in_coord_x, in_coord_y, in_coord_z, in_half_size);
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (answers_due.size() == 0) begin
        $error("result beat with no test pending");
        errors++;
      end else begin
        want = answers_due.pop_front();
        if (out_hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, out_hit);
          errors++;
        end
        if (out_overflowed !== want.ovf) begin
          $error("overflowed: expected %0d, got %0d", want.ovf, out_overflowed);
          errors++;
        end
        if (out_vertices_held !== want.cnt) begin
          $error("vertices_held: expected %0d, got %0d", want.cnt, out_vertices_held);
          errors++;
        end
      end
    end
  end

  // ---------------- end of run ----------------
  initial begin
    @(posedge rst_n);
    repeat (4) @(posedge clk);
    while (pend_beats.size() > 0 || in_valid || answers_due.size() > 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (errors == 0 && answers_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2000ms;
    $display("FAILURE");
    $finish;
  end

endmodule
